[rtl/tccs_pkg.sv]
// Shared types and constants of the text console cursor and scroll engine.
`default_nettype none

package tccs_pkg;

    // Cell indexes, cursor and display start are all 14-bit cell numbers.
    localparam int CELL_W = 14;

    // Attribute byte that the default colour register holds after reset.
    localparam logic [7:0] DEFAULT_COLOR_RST = 8'd7;

    // Character codes with a meaning of their own.
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    // Command codes on the input channel.
    localparam logic [2:0] CMD_PUT_CHAR    = 3'd0;
    localparam logic [2:0] CMD_GOTO        = 3'd1;
    localparam logic [2:0] CMD_SET_COLOR   = 3'd2;
    localparam logic [2:0] CMD_RESET_COLOR = 3'd3;
    localparam logic [2:0] CMD_CLEAR       = 3'd4;
    localparam logic [2:0] CMD_SCROLL_UP   = 3'd5;
    localparam logic [2:0] CMD_SCROLL_DOWN = 3'd6;

    // Decoded operations handed from the front end to the execution end.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_PRINT,
        OP_GOTO,
        OP_SET_ATTR,
        OP_RESET_ATTR,
        OP_CLEAR,
        OP_SCROLL_UP,
        OP_SCROLL_DOWN
    } op_t;

    // One decoded command: the operation, its byte operand (character or
    // attribute) and the goto target cell.
    typedef struct packed {
        op_t               op;
        logic [7:0]        data;
        logic [CELL_W-1:0] target;
    } item_t;

    // One result of the block.
    typedef struct packed {
        logic              clear_request;
        logic [CELL_W-1:0] display_start;
        logic [CELL_W-1:0] cursor_pos;
        logic [7:0]        write_attr;
        logic [7:0]        write_char;
        logic [CELL_W-1:0] write_cell;
        logic              write_enable;
    } result_t;

endpackage

`default_nettype wire

[rtl/tccs_front.sv]
// Command decoder: classifies commands and resolves goto targets.
`default_nettype none

module tccs_front #(
    parameter int WIDTH  = 80,
    parameter int HEIGHT = 25,
    parameter int CELLS  = 16384
) (
    input  logic                    [2:0] cmd,
    input  logic                    [7:0] char_code,
    input  logic signed             [7:0] col,
    input  logic signed             [7:0] row,
    input  logic                    [7:0] attr_value,
    output tccs_pkg::item_t               item,
    output logic [$clog2((CELLS+WIDTH-1)/WIDTH)-1:0] goto_row,
    output logic [$clog2(WIDTH)-1:0]      goto_col
);

    localparam int ROWS_CEIL = (CELLS + WIDTH - 1) / WIDTH;
    localparam int ROW_W     = $clog2(ROWS_CEIL);
    localparam int COL_W     = $clog2(WIDTH);
    localparam int POS_W     = $clog2(HEIGHT * WIDTH + CELLS);
    localparam int LAST_ROW  = (CELLS - 1) / WIDTH;
    localparam int LAST_COL  = (CELLS - 1) % WIDTH;

    logic [COL_W-1:0] x_clamped;
    logic [6:0]       y_clamped;
    logic [POS_W-1:0] pos;
    logic             pos_saturated;

    // Clamp the goto coordinates to the screen.
    always_comb begin
        if (col[7]) begin
            x_clamped = '0;
        end else if (int'(col[6:0]) > WIDTH - 1) begin
            x_clamped = COL_W'(WIDTH - 1);
        end else begin
            x_clamped = COL_W'(col[6:0]);
        end

        if (row[7]) begin
            y_clamped = '0;
        end else if (int'(row[6:0]) > HEIGHT - 1) begin
            y_clamped = 7'(HEIGHT - 1);
        end else begin
            y_clamped = row[6:0];
        end
    end

    assign pos           = POS_W'(y_clamped) * POS_W'(WIDTH) + POS_W'(x_clamped);
    assign pos_saturated = pos > POS_W'(CELLS - 1);

    always_comb begin
        item.op   = tccs_pkg::OP_NOP;
        item.data = char_code;

        if (pos_saturated) begin
            item.target = tccs_pkg::CELL_W'(CELLS - 1);
            goto_row    = ROW_W'(LAST_ROW);
            goto_col    = COL_W'(LAST_COL);
        end else begin
            item.target = pos[tccs_pkg::CELL_W-1:0];
            goto_row    = ROW_W'(y_clamped);
            goto_col    = x_clamped;
        end

        unique case (cmd)
            tccs_pkg::CMD_PUT_CHAR: begin
                priority if (char_code == tccs_pkg::CH_NEWLINE) begin
                    item.op = tccs_pkg::OP_NEWLINE;
                end else if (char_code == tccs_pkg::CH_BACKSPACE) begin
                    item.op = tccs_pkg::OP_BACKSPACE;
                end else begin
                    item.op = tccs_pkg::OP_PRINT;
                end
            end
            tccs_pkg::CMD_GOTO:        item.op = tccs_pkg::OP_GOTO;
            tccs_pkg::CMD_SET_COLOR: begin
                item.op   = tccs_pkg::OP_SET_ATTR;
                item.data = attr_value;
            end
            tccs_pkg::CMD_RESET_COLOR: item.op = tccs_pkg::OP_RESET_ATTR;
            tccs_pkg::CMD_CLEAR:       item.op = tccs_pkg::OP_CLEAR;
            tccs_pkg::CMD_SCROLL_UP:   item.op = tccs_pkg::OP_SCROLL_UP;
            tccs_pkg::CMD_SCROLL_DOWN: item.op = tccs_pkg::OP_SCROLL_DOWN;
            default:                   item.op = tccs_pkg::OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

[rtl/tccs_queue.sv]
// Two-entry queue between the command decoder and the execution end.
`default_nettype none

module tccs_queue #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  logic [DATA_W-1:0] wr_data,
    output logic              rd_valid,
    input  logic              rd_pop,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] entry_reg [2];
    logic [1:0]        count_reg, count_next;
    logic              wr_ptr_reg, rd_ptr_reg;
    logic              push, pop;

    assign wr_ready   = count_reg != 2'd2;
    assign rd_valid   = count_reg != 2'd0;
    assign rd_data    = entry_reg[rd_ptr_reg];
    assign push       = wr_valid && wr_ready;
    assign pop        = rd_pop && rd_valid;
    assign count_next = count_reg + 2'(push) - 2'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[rtl/tccs_back.sv]
// Execution end: cursor, display start and attribute state plus the result register.
`default_nettype none

module tccs_back #(
    parameter int WIDTH  = 80,
    parameter int HEIGHT = 25,
    parameter int CELLS  = 16384
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [7:0]              cfg_wr_data,
    input  logic                    q_valid,
    input  tccs_pkg::item_t         q_item,
    input  logic [$clog2((CELLS+WIDTH-1)/WIDTH)-1:0] q_row,
    input  logic [$clog2(WIDTH)-1:0] q_col,
    output logic                    q_pop,
    input  logic                    m_tready,
    output logic                    m_tvalid,
    output tccs_pkg::result_t       m_result
);

    localparam int ROWS_CEIL = (CELLS + WIDTH - 1) / WIDTH;
    localparam int ROW_W     = $clog2(ROWS_CEIL);
    localparam int COL_W     = $clog2(WIDTH);
    localparam int SUM_W     = $clog2(HEIGHT * WIDTH + CELLS) + 1;
    localparam int RCMP_W    = $clog2(ROWS_CEIL + HEIGHT) + 1;
    localparam int CW        = tccs_pkg::CELL_W;

    logic [CW-1:0]    cursor_reg, cursor_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [CW-1:0]    start_reg, start_next;
    logic [ROW_W-1:0] srow_reg, srow_next;
    logic [7:0]       attr_reg, attr_next;
    logic [7:0]       default_reg;
    logic             m_valid_reg;
    tccs_pkg::result_t res_reg, res;

    logic              scroll_check;
    logic [SUM_W-1:0]  window_end;
    logic [SUM_W-1:0]  line_base;
    logic [RCMP_W-1:0] row_ext, limit_ext;

    assign q_pop    = q_valid && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_result = res_reg;

    always_comb begin
        cursor_next  = cursor_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        start_next   = start_reg;
        srow_next    = srow_reg;
        attr_next    = attr_reg;
        scroll_check = 1'b0;
        res          = '0;
        window_end   = SUM_W'(start_reg) + SUM_W'(HEIGHT * WIDTH);

        unique case (q_item.op)
            tccs_pkg::OP_NEWLINE: begin
                scroll_check = 1'b1;
                if (cursor_reg < CW'(CELLS - WIDTH)) begin
                    cursor_next = cursor_reg - CW'(col_reg) + CW'(WIDTH);
                    row_next    = row_reg + ROW_W'(1);
                    col_next    = '0;
                end
            end
            tccs_pkg::OP_BACKSPACE: begin
                scroll_check = 1'b1;
                if (cursor_reg != '0) begin
                    cursor_next = cursor_reg - CW'(1);
                    if (col_reg == '0) begin
                        col_next = COL_W'(WIDTH - 1);
                        row_next = row_reg - ROW_W'(1);
                    end else begin
                        col_next = col_reg - COL_W'(1);
                    end
                    res.write_enable = 1'b1;
                    res.write_cell   = cursor_reg - CW'(1);
                    res.write_char   = tccs_pkg::CH_SPACE;
                    res.write_attr   = attr_reg;
                end
            end
            tccs_pkg::OP_PRINT: begin
                scroll_check = 1'b1;
                if (cursor_reg < CW'(CELLS - 1)) begin
                    cursor_next = cursor_reg + CW'(1);
                    if (col_reg == COL_W'(WIDTH - 1)) begin
                        col_next = '0;
                        row_next = row_reg + ROW_W'(1);
                    end else begin
                        col_next = col_reg + COL_W'(1);
                    end
                    res.write_enable = 1'b1;
                    res.write_cell   = cursor_reg;
                    res.write_char   = q_item.data;
                    res.write_attr   = attr_reg;
                end
            end
            tccs_pkg::OP_GOTO: begin
                cursor_next = q_item.target;
                row_next    = q_row;
                col_next    = q_col;
            end
            tccs_pkg::OP_SET_ATTR:   attr_next = q_item.data;
            tccs_pkg::OP_RESET_ATTR: attr_next = default_reg;
            tccs_pkg::OP_CLEAR: begin
                cursor_next       = '0;
                row_next          = '0;
                col_next          = '0;
                start_next        = '0;
                srow_next         = '0;
                res.clear_request = 1'b1;
            end
            tccs_pkg::OP_SCROLL_UP: begin
                if (start_reg != '0) begin
                    start_next = start_reg - CW'(WIDTH);
                    srow_next  = srow_reg - ROW_W'(1);
                end
            end
            tccs_pkg::OP_SCROLL_DOWN: begin
                if (window_end < SUM_W'(CELLS)) begin
                    start_next = start_reg + CW'(WIDTH);
                    srow_next  = srow_reg + ROW_W'(1);
                end
            end
            tccs_pkg::OP_NOP: begin
            end
            default: begin
            end
        endcase

        // When the cursor row falls below the window, the window moves so
        // that the cursor row becomes its last row. That row never lies past
        // the last row of the buffer, so no further limit applies.
        row_ext   = RCMP_W'(row_next);
        limit_ext = RCMP_W'(srow_reg) + RCMP_W'(HEIGHT);
        line_base = SUM_W'(cursor_next) - SUM_W'(col_next)
                    - SUM_W'((HEIGHT - 1) * WIDTH);
        if (scroll_check && row_ext >= limit_ext) begin
            srow_next  = row_next - ROW_W'(HEIGHT - 1);
            start_next = line_base[CW-1:0];
        end

        res.cursor_pos    = cursor_next;
        res.display_start = start_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg  <= CW'(WIDTH * 4);
            row_reg     <= ROW_W'(4);
            col_reg     <= '0;
            start_reg   <= '0;
            srow_reg    <= '0;
            attr_reg    <= tccs_pkg::DEFAULT_COLOR_RST;
            default_reg <= tccs_pkg::DEFAULT_COLOR_RST;
            m_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                cursor_reg <= cursor_next;
                row_reg    <= row_next;
                col_reg    <= col_next;
                start_reg  <= start_next;
                srow_reg   <= srow_next;
                attr_reg   <= attr_next;
            end
            if (cfg_wr_en) begin
                default_reg <= cfg_wr_data;
            end
            if (q_pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

[rtl/text_console_cursor_scroll_core.sv]
// Top level of the text console cursor and scroll engine.
//
// The input stream carries one console command per transfer: s_tuser holds
// the command code and s_tdata its operands. Every command yields exactly one
// result transfer on the output stream, in order, describing an optional
// cell write, the cursor and display start after the command, and a clear
// request. The default colour register is to be written via cfg_wr_en and
// cfg_wr_data only while no command is in flight; the block does not enforce it.
//
// A decoder classifies each command and resolves goto targets (one constant
// multiply), a two-entry queue follows, and the execution end updates the
// cursor, window and attribute state and registers the result. Each command
// passes through the queue and the result register before its result is on
// m_tdata. One command per cycle is sustained while the receiver takes the
// results, since the state update including auto-scroll is combinational on
// row and column counters kept beside the cursor.
//
// Synchronous reset puts the cursor four rows in, the display start at cell
// zero and the attribute and default colour at 7. When the receiver stalls,
// the result register holds, the queue fills up to its two entries and then
// s_tready stays low until the receiver takes the waiting result.
`default_nettype none

module text_console_cursor_scroll_core #(
    parameter int WIDTH  = 80,
    parameter int HEIGHT = 25,
    parameter int CELLS  = 16384
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Default colour register.
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // Command stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, from bit 0: char_code[7:0], col[15:8], row[23:16], attr_value[31:24]
    input  logic [31:0] s_tdata,
    // s_tuser: cmd[2:0]
    input  logic [2:0]  s_tuser,
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, from bit 0: write_enable[0], write_cell[14:1], write_char[22:15],
    // write_attr[30:23], cursor_pos[44:31], display_start[58:45],
    // clear_request[59], zero fill[63:60]
    output logic [63:0] m_tdata
);

    localparam int ROW_W  = $clog2((CELLS + WIDTH - 1) / WIDTH);
    localparam int COL_W  = $clog2(WIDTH);
    localparam int ITEM_W = $bits(tccs_pkg::item_t);
    localparam int Q_W    = COL_W + ROW_W + ITEM_W;

    tccs_pkg::item_t   dec_item, q_item;
    logic [ROW_W-1:0]  dec_row, q_row;
    logic [COL_W-1:0]  dec_col, q_col;
    logic [Q_W-1:0]    q_rd_data;
    logic              q_valid, q_pop;
    tccs_pkg::result_t result;

    tccs_front #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT),
        .CELLS  (CELLS)
    ) u_front (
        .cmd        (s_tuser),
        .char_code  (s_tdata[7:0]),
        .col        ($signed(s_tdata[15:8])),
        .row        ($signed(s_tdata[23:16])),
        .attr_value (s_tdata[31:24]),
        .item       (dec_item),
        .goto_row   (dec_row),
        .goto_col   (dec_col)
    );

    tccs_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_data  ({dec_col, dec_row, dec_item}),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_rd_data)
    );

    assign q_item = q_rd_data[ITEM_W-1:0];
    assign q_row  = q_rd_data[ITEM_W +: ROW_W];
    assign q_col  = q_rd_data[ITEM_W + ROW_W +: COL_W];

    tccs_back #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT),
        .CELLS  (CELLS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_row       (q_row),
        .q_col       (q_col),
        .q_pop       (q_pop),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_result    (result)
    );

    // The result struct is declared from its last field down, so its packed
    // form already has write_enable in the lowest bit.
    assign m_tdata = {4'd0, result};

`ifndef SYNTHESIS
    // A clear returns cursor and window to the origin and writes no cell.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && result.clear_request |->
            result.cursor_pos == '0 && result.display_start == '0 &&
            !result.write_enable)
        else $error("clear result with cursor, window or write set");

    // A written cell is always the new cursor cell or the one just before it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && result.write_enable |->
            result.write_cell == result.cursor_pos ||
            result.write_cell + 14'd1 == result.cursor_pos)
        else $error("written cell not next to the cursor");

    // Without a write the write fields read as zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !result.write_enable |->
            result.write_cell == '0 && result.write_char == '0 &&
            result.write_attr == '0)
        else $error("write fields set on a result without a write");

    // The queue only refuses commands while the execution end is stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_valid && m_tvalid)
        else $error("command stream stalled while the result path is free");
`endif

endmodule

`default_nettype wire

[tb/tb_text_console_cursor_scroll_core.sv]
// Self-checking testbench of the text console cursor and scroll engine.
`timescale 1ns / 100ps

module tb_text_console_cursor_scroll_core;

    // Geometry of the console under test; passed to the block as well.
    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int NCELLS = 16384;
    localparam int SCREEN = COLS * ROWS;

    // Command code that the block does not use.
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    // Cycles without any transfer on either side before the run is abandoned.
    localparam int STALL_LIMIT = 5000;
    // Cycles allowed after the last expected result before registers change.
    localparam int SETTLE_CYCLES = 8;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    // s_tdata, from bit 0: char_code[7:0], col[15:8], row[23:16], attr_value[31:24]
    logic [31:0] s_tdata     = 32'd0;
    // s_tuser: cmd[2:0]
    logic [2:0]  s_tuser     = 3'd0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    // m_tdata, from bit 0: write_enable, write_cell, write_char, write_attr,
    // cursor_pos, display_start, clear_request, zero fill
    logic [63:0] m_tdata;

    // Shadow of the console state, advanced once per accepted command.
    int         cur_pos;
    int         win_top;
    logic [7:0] cur_color;
    logic [7:0] reg_default_color;

    // Results predicted for commands that were accepted but not yet answered.
    tccs_pkg::result_t console_results_q[$];

    // Chance, in percent, that a side idles in a given cycle.
    int send_idle_pct = 35;
    int recv_idle_pct = 35;

    int fail_count   = 0;
    int stall_cycles = 0;

    text_console_cursor_scroll_core #(
        .WIDTH (COLS),
        .HEIGHT(ROWS),
        .CELLS (NCELLS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Computes the result of one command and advances the shadow state. The
    // arithmetic is done on plain integers so that no intermediate wraps.
    function automatic tccs_pkg::result_t console_update(input logic [2:0] cmd,
                                                         input logic [7:0] ch,
                                                         input logic [7:0] col,
                                                         input logic [7:0] row,
                                                         input logic [7:0] attr);
        tccs_pkg::result_t res;
        int x;
        int y;
        int win_end;
        int rows_needed;
        int rows_left;
        res = '0;
        x = $signed(col);
        y = $signed(row);
        case (cmd)
            tccs_pkg::CMD_PUT_CHAR: begin
                if (ch == tccs_pkg::CH_NEWLINE) begin
                    // Within the last COLS cells of the buffer a newline leaves the cursor alone.
                    if (cur_pos < NCELLS - COLS)
                        cur_pos = COLS * (cur_pos / COLS + 1);
                end else if (ch == tccs_pkg::CH_BACKSPACE) begin
                    // At cell zero there is nothing to rub out.
                    if (cur_pos > 0) begin
                        cur_pos--;
                        res.write_enable = 1'b1;
                        res.write_cell   = cur_pos[tccs_pkg::CELL_W-1:0];
                        res.write_char   = tccs_pkg::CH_SPACE;
                        res.write_attr   = cur_color;
                    end
                end else if (cur_pos < NCELLS - 1) begin
                    // The last cell of the buffer is never written by a print.
                    res.write_enable = 1'b1;
                    res.write_cell   = cur_pos[tccs_pkg::CELL_W-1:0];
                    res.write_char   = ch;
                    res.write_attr   = cur_color;
                    cur_pos++;
                end
                // The window follows the cursor by whole rows, but never runs
                // further than needed to cover the end of the buffer.
                win_end = win_top + SCREEN;
                if (cur_pos >= win_end) begin
                    rows_needed = (cur_pos - win_end) / COLS + 1;
                    rows_left = (NCELLS > win_end) ? (NCELLS - win_end + COLS - 1) / COLS : 0;
                    if (rows_needed > rows_left)
                        rows_needed = rows_left;
                    win_top += rows_needed * COLS;
                end
            end
            tccs_pkg::CMD_GOTO: begin
                if (x < 0) x = 0;
                if (x > COLS - 1) x = COLS - 1;
                if (y < 0) y = 0;
                if (y > ROWS - 1) y = ROWS - 1;
                cur_pos = y * COLS + x;
                if (cur_pos > NCELLS - 1)
                    cur_pos = NCELLS - 1;
            end
            tccs_pkg::CMD_SET_COLOR:   cur_color = attr;
            tccs_pkg::CMD_RESET_COLOR: cur_color = reg_default_color;
            tccs_pkg::CMD_CLEAR: begin
                cur_pos = 0;
                win_top = 0;
                res.clear_request = 1'b1;
            end
            tccs_pkg::CMD_SCROLL_UP: begin
                if (win_top > 0)
                    win_top = (win_top >= COLS) ? win_top - COLS : 0;
            end
            tccs_pkg::CMD_SCROLL_DOWN: begin
                if (win_top + SCREEN < NCELLS)
                    win_top += COLS;
            end
            default: ;
        endcase
        res.cursor_pos    = cur_pos[tccs_pkg::CELL_W-1:0];
        res.display_start = win_top[tccs_pkg::CELL_W-1:0];
        return res;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Sends one command. The valid stays high on return so that a following
    // command can go out back to back; idle cycles are inserted up front.
    task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] ch,
                            input logic [7:0] col, input logic [7:0] row,
                            input logic [7:0] attr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {attr, row, col, ch};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        // The transfer took place at this edge.
        console_results_q.push_back(console_update(cmd, ch, col, row, attr));
    endtask

    // Stops sending and waits until every predicted result has been taken,
    // then lets the pipeline settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (console_results_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes the default colour register while no command is in flight.
    task automatic write_default_color(input logic [7:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        reg_default_color = value;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_random_cmd();
        int pick;
        logic [2:0] cmd;
        logic [7:0] ch;
        pick = $urandom_range(99);
        ch = 8'($urandom_range(255));
        // Mostly printing and newlines, so that the window gets pushed down;
        // goto with random signed targets lands on the clamped last row often.
        if (pick < 50)      cmd = tccs_pkg::CMD_PUT_CHAR;
        else if (pick < 65) begin cmd = tccs_pkg::CMD_PUT_CHAR; ch = tccs_pkg::CH_NEWLINE; end
        else if (pick < 73) begin cmd = tccs_pkg::CMD_PUT_CHAR; ch = tccs_pkg::CH_BACKSPACE; end
        else if (pick < 81) cmd = tccs_pkg::CMD_GOTO;
        else if (pick < 85) cmd = tccs_pkg::CMD_SET_COLOR;
        else if (pick < 88) cmd = tccs_pkg::CMD_RESET_COLOR;
        else if (pick < 89) cmd = tccs_pkg::CMD_CLEAR;
        else if (pick < 93) cmd = tccs_pkg::CMD_SCROLL_UP;
        else if (pick < 97) cmd = tccs_pkg::CMD_SCROLL_DOWN;
        else                cmd = CMD_UNUSED;
        send_cmd(cmd, ch, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_random_cmd();
    endtask

    // Extremes of every field and each command at least once, including the unused code.
    task automatic test_directed_commands();
        send_cmd(tccs_pkg::CMD_PUT_CHAR, 8'h41, 8'h00, 8'h00, 8'h00);
        send_cmd(tccs_pkg::CMD_PUT_CHAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(tccs_pkg::CMD_PUT_CHAR, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(tccs_pkg::CMD_PUT_CHAR, tccs_pkg::CH_NEWLINE, 8'h00, 8'h00, 8'h00);
        send_cmd(tccs_pkg::CMD_PUT_CHAR, tccs_pkg::CH_BACKSPACE, 8'h00, 8'h00, 8'h00);
        send_cmd(tccs_pkg::CMD_GOTO, 8'h00, 8'h80, 8'h80, 8'h00);
        send_cmd(tccs_pkg::CMD_GOTO, 8'h00, 8'h7F, 8'h7F, 8'h00);
        send_cmd(tccs_pkg::CMD_GOTO, 8'h00, 8'd79, 8'd24, 8'h00);
        // The print at the bottom right corner pushes the window down one row.
        send_cmd(tccs_pkg::CMD_PUT_CHAR, 8'h5A, 8'h00, 8'h00, 8'h00);
        send_cmd(tccs_pkg::CMD_SET_COLOR, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_cmd(tccs_pkg::CMD_PUT_CHAR, 8'h7E, 8'h00, 8'h00, 8'h00);
        send_cmd(tccs_pkg::CMD_SET_COLOR, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        send_cmd(tccs_pkg::CMD_PUT_CHAR, tccs_pkg::CH_BACKSPACE, 8'h00, 8'h00, 8'h00);
        send_cmd(tccs_pkg::CMD_RESET_COLOR, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(tccs_pkg::CMD_SCROLL_UP, 8'h00, 8'h00, 8'h00, 8'h00);
        // The window is back at the top, so this scroll is ignored.
        send_cmd(tccs_pkg::CMD_SCROLL_UP, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(tccs_pkg::CMD_SCROLL_DOWN, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(tccs_pkg::CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // Backspace at cell zero writes nothing.
        send_cmd(tccs_pkg::CMD_PUT_CHAR, tccs_pkg::CH_BACKSPACE, 8'h00, 8'h00, 8'h00);
        send_cmd(tccs_pkg::CMD_GOTO, 8'h00, 8'd80, 8'hFF, 8'h00);
        send_cmd(tccs_pkg::CMD_PUT_CHAR, 8'h20, 8'h00, 8'h00, 8'h00);
    endtask

    // The reset-colour command must pick up each new register value, while
    // the write itself leaves the current attribute untouched.
    task automatic test_default_color(input logic [7:0] value);
        write_default_color(value);
        send_cmd(tccs_pkg::CMD_PUT_CHAR, 8'h31, 8'h00, 8'h00, 8'h00);
        send_cmd(tccs_pkg::CMD_RESET_COLOR, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(tccs_pkg::CMD_PUT_CHAR, 8'h32, 8'h00, 8'h00, 8'h00);
    endtask

    // Walks the cursor to the very end of the buffer and the window back up.
    task automatic test_buffer_end();
        send_cmd(tccs_pkg::CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
        // Enough newlines to reach the last row, and some that must stick there.
        repeat (NCELLS / COLS + 6)
            send_cmd(tccs_pkg::CMD_PUT_CHAR, tccs_pkg::CH_NEWLINE, 8'h00, 8'h00, 8'h00);
        // Print a row's worth, which runs the cursor onto the final cell and keeps printing there unwritten.
        for (int i = 0; i < COLS; i++)
            send_cmd(tccs_pkg::CMD_PUT_CHAR, 8'(8'h61 + i % 26), 8'h00, 8'h00, 8'h00);
        send_cmd(tccs_pkg::CMD_PUT_CHAR, tccs_pkg::CH_BACKSPACE, 8'h00, 8'h00, 8'h00);
        send_cmd(tccs_pkg::CMD_PUT_CHAR, 8'h21, 8'h00, 8'h00, 8'h00);
        send_cmd(tccs_pkg::CMD_PUT_CHAR, 8'h22, 8'h00, 8'h00, 8'h00);
        // The window already covers the end, so scrolling down is ignored.
        repeat (3) send_cmd(tccs_pkg::CMD_SCROLL_DOWN, 8'h00, 8'h00, 8'h00, 8'h00);
        repeat (NCELLS / COLS + 3)
            send_cmd(tccs_pkg::CMD_SCROLL_UP, 8'h00, 8'h00, 8'h00, 8'h00);
        repeat (NCELLS / COLS)
            send_cmd(tccs_pkg::CMD_SCROLL_DOWN, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(tccs_pkg::CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    // The receiver stalls at random and checks every result transfer
    // against the oldest prediction.
    always @(posedge aclk) begin
        tccs_pkg::result_t want;
        tccs_pkg::result_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_tvalid && m_tready) begin
                got = tccs_pkg::result_t'(m_tdata[59:0]);
                if (console_results_q.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    fail_count++;
                end else begin
                    want = console_results_q.pop_front();
                    check_field("write_enable", want.write_enable, got.write_enable);
                    check_field("write_cell", want.write_cell, got.write_cell);
                    check_field("write_char", want.write_char, got.write_char);
                    check_field("write_attr", want.write_attr, got.write_attr);
                    check_field("cursor_pos", want.cursor_pos, got.cursor_pos);
                    check_field("display_start", want.display_start, got.display_start);
                    check_field("clear_request", want.clear_request, got.clear_request);
                end
            end
        end
    end

    // Watchdog: any transfer on either side counts as progress.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        reg_default_color = tccs_pkg::DEFAULT_COLOR_RST;
        cur_pos   = COLS * 4;
        win_top   = 0;
        cur_color = tccs_pkg::DEFAULT_COLOR_RST;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_commands();
        test_default_color(8'h00);
        test_default_color(8'hFF);
        test_default_color(8'($urandom_range(255)));
        test_buffer_end();

        write_default_color(tccs_pkg::DEFAULT_COLOR_RST);
        test_random_traffic(100);

        // A long stretch with neither side ever idling.
        write_default_color(8'($urandom_range(255)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(150);
        send_idle_pct = 35;
        recv_idle_pct = 35;

        // Halfway through, the sender holds off until the block has answered
        // every command it took.
        write_default_color(8'hFF);
        test_random_traffic(75);
        drain_results();
        test_random_traffic(75);

        write_default_color(8'h00);
        test_random_traffic(110);

        drain_results();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
